// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent in the same cycle as the antecedent.
`define XRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define XRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent at a later cycle than the antecedent.
`define XRS_ASSERT_LATER3(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
    else $error(msg);

`endif

// ===== rtl/xrs_pkg.sv =====
// Package for the xorshift1024* random source: constants, seed table, types.
// No dependencies.
`timescale 1ns / 1ps

package xrs_pkg;

  localparam int STATE_WORDS = 16;
  localparam int PTR_W       = $clog2(STATE_WORDS);
  localparam int WORD_W      = 64;
  localparam int VAL_W       = 32;
  localparam int IN_W        = 40;
  localparam int OUT_W       = 32;

  localparam logic [63:0] SEED64   = 64'h05a3ae52de3bbf0a;
  localparam logic [63:0] MULT64   = 64'd2685821657736338717;
  localparam logic [63:0] MULT1024 = 64'd1181783497276652981;
  localparam logic [31:0] MULT_LO  = MULT1024[31:0];

  localparam int SH_A = 31;
  localparam int SH_B = 11;
  localparam int SH_C = 30;
  localparam int SEED_SH_A = 12;
  localparam int SEED_SH_B = 25;
  localparam int SEED_SH_C = 27;

  typedef logic [WORD_W-1:0] word_tbl_t [STATE_WORDS];

  // xorshift64* outputs from the fixed seed, worked out at elaboration
  function automatic word_tbl_t seed_table();
    word_tbl_t   tbl;
    logic [63:0] x;
    x = SEED64;
    for (int i = 0; i < STATE_WORDS; i++) begin
      x = x ^ (x >> SEED_SH_A);
      x = x ^ (x << SEED_SH_B);
      x = x ^ (x >> SEED_SH_C);
      tbl[i] = x * MULT64;
    end
    return tbl;
  endfunction

  localparam word_tbl_t SEED_TABLE = seed_table();

  typedef enum logic [1:0] {
    RES_ONE  = 2'd0,
    RES_RAW  = 2'd1,
    RES_MASK = 2'd2,
    RES_REM  = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     rd;
    logic     wr;
    logic     mul;
    logic     div_start;
    logic     load_out;
    res_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic lim_zero;
    logic lim_ones;
    logic div_done;
  } status_t;

endpackage

// ===== rtl/xrs_div.sv =====
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// Depends on xrs_pkg.
`timescale 1ns / 1ps

module xrs_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [xrs_pkg::VAL_W-1:0] dividend,
  input  logic [xrs_pkg::VAL_W-1:0] divisor,
  output logic                     done,
  output logic [xrs_pkg::VAL_W-1:0] rem
);
  import xrs_pkg::*;

  localparam int CNT_W = $clog2(VAL_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] dvd;
  logic [VAL_W-1:0] dsr;
  logic [VAL_W:0]   sh;

  assign sh = {rem, dvd[VAL_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (sh >= {1'b0, dsr}) begin
        rem <= VAL_W'(sh - {1'b0, dsr});
      end else begin
        rem <= sh[VAL_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/xrs_datapath.sv =====
// Datapath: request capture, generator word store, mixer, multiplier, output register.
// Depends on xrs_pkg and xrs_div.
`timescale 1ns / 1ps

module xrs_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [xrs_pkg::IN_W-1:0]  in_data,
  input  xrs_pkg::cmd_t            cmd,
  output xrs_pkg::status_t         status,
  output logic [xrs_pkg::OUT_W-1:0] out_data
);
  import xrs_pkg::*;

  logic                   op;
  logic [VAL_W-1:0]       limit;
  logic [PTR_W-1:0]       ptr;
  logic [PTR_W-1:0]       ptr_inc;
  logic [STATE_WORDS-1:0] valid;
  logic [WORD_W-1:0]      mem [STATE_WORDS];
  logic [WORD_W-1:0]      rd0;
  logic [WORD_W-1:0]      rd1;
  logic [WORD_W-1:0]      s0;
  logic [WORD_W-1:0]      s1a;
  logic [WORD_W-1:0]      s1b;
  logic [WORD_W-1:0]      new_word;
  logic [VAL_W-1:0]       lo32;
  logic [VAL_W-1:0]       raw;
  logic [VAL_W-1:0]       rem;
  logic                   div_done;
  logic [OUT_W-1:0]       res;

  assign ptr_inc = ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= in_data[0];
      limit <= in_data[VAL_W:1];
    end
  end

  assign status.op       = op;
  assign status.lim_zero = (limit == '0);
  assign status.lim_ones = (limit == '1);
  assign status.div_done = div_done;

  // word store; entries not yet written read as the seeded values
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd0 <= valid[ptr]     ? mem[ptr]     : SEED_TABLE[ptr];
      rd1 <= valid[ptr_inc] ? mem[ptr_inc] : SEED_TABLE[ptr_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[ptr_inc] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ptr   <= '0;
    end else if (cmd.wr) begin
      valid[ptr_inc] <= 1'b1;
      ptr            <= ptr_inc;
    end
  end

  assign s1a      = rd1 ^ (rd1 << SH_A);
  assign s1b      = s1a ^ (s1a >> SH_B);
  assign s0       = rd0 ^ (rd0 >> SH_C);
  assign new_word = s0 ^ s1b;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      lo32 <= new_word[VAL_W-1:0];
    end
    if (cmd.mul) begin
      raw <= VAL_W'(lo32 * MULT_LO);
    end
  end

  xrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (raw),
    .divisor  (limit),
    .done     (div_done),
    .rem      (rem)
  );

  always_comb begin
    unique case (cmd.sel)
      RES_ONE:  res = OUT_W'(1);
      RES_RAW:  res = raw;
      RES_MASK: res = raw & limit;
      RES_REM:  res = rem;
      default:  res = raw;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= res;
    end
  end

endmodule

// ===== rtl/xrs_ctrl.sv =====
// Controller: runs one request via read, mix, multiply, remainder as needed.
// Depends on xrs_pkg.
`timescale 1ns / 1ps

module xrs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  xrs_pkg::status_t status,
  output xrs_pkg::cmd_t    cmd
);
  import xrs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_MIX   = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_DIVGO = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    priority if (status.op) begin
      cmd.sel = RES_MASK;
    end else if (status.lim_zero) begin
      cmd.sel = RES_ONE;
    end else if (status.lim_ones) begin
      cmd.sel = RES_RAW;
    end else begin
      cmd.sel = RES_REM;
    end
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        if (!status.op && status.lim_zero) begin
          state_next = ST_OUT;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd.wr     = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (!status.op && !status.lim_ones) begin
          state_next = ST_DIVGO;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/xorshift1024star_random_source.sv =====
// xorshift1024* random source, one request at a time.
// Path from request to result: a bounded draw with limit zero goes from capture straight to the output,
// a masked or full-range draw passes read, mix and multiply, and a modulo draw also runs the divider.
// A new request is taken the cycle after the result is loaded into the output register.
// Synchronous reset: pointer to zero, words read as the seeded table, ready at once.
// Depends on xrs_pkg, xrs_ctrl, xrs_datapath.
`timescale 1ns / 1ps

module xorshift1024star_random_source (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [xrs_pkg::IN_W-1:0]  s_tdata,  // [0] op, [32:1] limit, [39:33] zero
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [xrs_pkg::OUT_W-1:0] m_tdata   // [31:0] value
);
  import xrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  xrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  xrs_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .out_data (m_tdata)
  );

endmodule

// ===== rtl/xrs_checker.sv =====
// Port-level checks for the xorshift1024* random source, bound to the top level.
// Depends on xrs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xrs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [xrs_pkg::IN_W-1:0]  s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [xrs_pkg::OUT_W-1:0] m_tdata
);
  import xrs_pkg::*;

  `XRS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped")
  `XRS_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "result changed")
  `XRS_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "request overlap")
  `XRS_ASSERT_LATER3(a_zero_limit, clk, rst, s_tvalid && s_tready && !s_tdata[0] && (s_tdata[VAL_W:1] == '0) && !m_tvalid, m_tvalid && (m_tdata == OUT_W'(1)), "zero limit result")

endmodule

bind xorshift1024star_random_source xrs_checker u_chk (.*);
